[rtl/vmalu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package vmalu_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned REG_COUNT_DEF = 256;

    typedef enum logic [4:0] {
        OP_NOP = 5'd0, OP_NOT = 5'd1, OP_ADD = 5'd2, OP_SUB = 5'd3,
        OP_MUL = 5'd4, OP_UDIV = 5'd5, OP_IMUL = 5'd6, OP_IDIV = 5'd7,
        OP_MOD = 5'd8, OP_EQ = 5'd9, OP_NEQ = 5'd10, OP_ULT = 5'd11,
        OP_ULTE = 5'd12, OP_SLT = 5'd13, OP_SLTE = 5'd14, OP_UGT = 5'd15,
        OP_UGTE = 5'd16, OP_SGT = 5'd17, OP_SGTE = 5'd18, OP_AND = 5'd19,
        OP_OR = 5'd20, OP_XOR = 5'd21, OP_COPY = 5'd22, OP_CONST = 5'd23,
        OP_JNZ = 5'd24, OP_JZ = 5'd25, OP_ASSERT = 5'd26
    } op_t;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_ASSERT = 2'd2;

endpackage
`default_nettype wire

[rtl/vm_register_alu_execute_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  direction  tdata fields (low bit up)                       tuser
// s_axis   in         req_type[4:0] dest_reg lhs_reg rhs_reg imm[63:0] -
// m_axis   out        write_done written_value[63:0] branch_taken err -
//
// every request runs bit-serially: an operand read state (ST_READ), an operand
// load step, then the shared serial unit in ST_RUN (lsb-first for add/sub/logic/
// compare, shift-add for mul, restoring radix-2 for div/mod), then a write
// state (ST_DONE) that also fills the output register shown in ST_OUT
// after reset the register file is swept to zero, entry by entry, with
// s_axis_tready low; results wait in an output register while m_axis stalls
// and the next request is taken only after that result has been accepted
module vm_register_alu_execute_core #(
    parameter int unsigned REG_COUNT = vmalu_pkg::REG_COUNT_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,   // req_type dest_reg lhs_reg rhs_reg immediate, pad
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata    // write_done written_value branch_taken error_code, pad
);
    import vmalu_pkg::*;

    localparam int unsigned IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int unsigned CW = $clog2(DATA_W + 1);

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_RUN, ST_DONE, ST_OUT} state_t;

    logic [DATA_W-1:0] regs [REG_COUNT];
    state_t state_reg;
    logic [IW:0] clr_reg;
    logic [CW-1:0] cnt_reg;
    logic [4:0] op_reg;
    logic [IW-1:0] dst_reg;
    logic [IW-1:0] lidx_reg, ridx_reg;
    logic [DATA_W-1:0] imm_reg;
    logic [DATA_W-1:0] a_reg, b_reg, acc_reg, q_reg, rd_a_reg, rd_b_reg;
    logic carry_reg, eq_reg, lt_reg, anz_reg, neg_reg;
    logic out_wd_reg, out_tk_reg;
    logic [1:0] out_err_reg;
    logic [DATA_W-1:0] out_val_reg;

    // index wraps modulo REG_COUNT, constant lookup over all 8-bit indexes
    typedef logic [IW-1:0] wrap_lut_t [256];

    function automatic wrap_lut_t build_wrap_lut();
        wrap_lut_t lut;
        for (int i = 0; i < 256; i++)
            lut[i] = IW'(i % REG_COUNT);
        return lut;
    endfunction

    localparam wrap_lut_t WRAP_LUT = build_wrap_lut();

    function automatic logic [IW-1:0] widx(input logic [7:0] r);
        return WRAP_LUT[r];
    endfunction

    op_t op;
    assign op = op_t'(op_reg);
    logic is_div, sdiv;
    assign is_div = (op == OP_UDIV) || (op == OP_IDIV) || (op == OP_MOD);
    assign sdiv = (op == OP_IDIV);
    logic is_mul;
    assign is_mul = (op == OP_MUL) || (op == OP_IMUL);

    // serial step signals
    logic abit, bbit, sbit, dbit;
    logic [DATA_W:0] rem_sh;
    logic [DATA_W:0] rem_sub;
    logic [DATA_W:0] madd;
    always_comb
    begin
        abit = a_reg[0];
        bbit = (op == OP_SUB) ? ~b_reg[0] : b_reg[0];
        sbit = abit ^ bbit ^ carry_reg;
        dbit = 1'b0;
        unique case (op)
            OP_AND: dbit = a_reg[0] & b_reg[0];
            OP_OR:  dbit = a_reg[0] | b_reg[0];
            OP_XOR: dbit = a_reg[0] ^ b_reg[0];
            default: dbit = sbit;
        endcase
        rem_sh = {acc_reg, q_reg[DATA_W-1]};
        rem_sub = rem_sh - {1'b0, b_reg};
        madd = {1'b0, acc_reg} + ((q_reg[0]) ? {1'b0, b_reg} : '0);
    end

    // compare: a-b bitwise, lsb first
    logic d_lt;
    assign d_lt = (a_reg[0] != b_reg[0]) ? b_reg[0] : lt_reg;

    logic [DATA_W-1:0] res_v;
    logic res_wr, res_tk;
    logic [1:0] res_err;
    logic sa, sb, slt, sgt, ult, ugt, eqv;
    always_comb
    begin
        sa = rd_a_reg[DATA_W-1];
        sb = rd_b_reg[DATA_W-1];
        ult = lt_reg;
        eqv = eq_reg;
        ugt = !lt_reg && !eq_reg;
        slt = (sa != sb) ? sa : ult;
        sgt = (sa != sb) ? sb : ugt;
        res_v = '0; res_wr = 1'b0; res_tk = 1'b0; res_err = ERR_NONE;
        case (op)
            OP_NOT:  begin res_wr = 1'b1; res_v = DATA_W'(!anz_reg); end
            OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_COPY, OP_CONST:
                begin res_wr = 1'b1; res_v = acc_reg; end
            OP_MUL, OP_IMUL: begin res_wr = 1'b1; res_v = a_reg; end
            OP_UDIV, OP_IDIV, OP_MOD:
                if (rd_b_reg == '0) res_err = ERR_DIV0;
                else
                begin
                    res_wr = 1'b1;
                    res_v = (op == OP_MOD) ? acc_reg : (neg_reg ? -q_reg : q_reg);
                end
            OP_EQ:   begin res_wr = 1'b1; res_v = DATA_W'(eqv); end
            OP_NEQ:  begin res_wr = 1'b1; res_v = DATA_W'(!eqv); end
            OP_ULT:  begin res_wr = 1'b1; res_v = DATA_W'(ult); end
            OP_ULTE: begin res_wr = 1'b1; res_v = DATA_W'(ult || eqv); end
            OP_SLT:  begin res_wr = 1'b1; res_v = DATA_W'(slt); end
            OP_SLTE: begin res_wr = 1'b1; res_v = DATA_W'(!sgt); end
            OP_UGT:  begin res_wr = 1'b1; res_v = DATA_W'(ugt); end
            OP_UGTE: begin res_wr = 1'b1; res_v = DATA_W'(!ult); end
            OP_SGT:  begin res_wr = 1'b1; res_v = DATA_W'(sgt); end
            OP_SGTE: begin res_wr = 1'b1; res_v = DATA_W'(!slt); end
            OP_JNZ:  if (anz_reg) begin res_wr = 1'b1; res_v = 64'd1; res_tk = 1'b1; end
            OP_JZ:   if (!anz_reg) begin res_wr = 1'b1; res_tk = 1'b1; end
            OP_ASSERT: if (!anz_reg) res_err = ERR_ASSERT;
            default: ;
        endcase
    end

    // register file: one write, two registered reads
    logic we;
    logic [IW-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    assign we = (state_reg == ST_CLEAR) || (state_reg == ST_DONE && res_wr);
    assign waddr = (state_reg == ST_CLEAR) ? clr_reg[IW-1:0] : dst_reg;
    assign wdata = (state_reg == ST_CLEAR) ? '0 : res_v;

    always_ff @(posedge clk)
    begin
        if (we) regs[waddr] <= wdata;
        rd_a_reg <= regs[lidx_reg];
        rd_b_reg <= regs[ridx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (IW+1)'(REG_COUNT - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE:
                    if (s_axis_tvalid) state_reg <= ST_READ;
                ST_READ:  state_reg <= ST_RUN;
                ST_RUN:
                    if (cnt_reg == CW'(DATA_W)) state_reg <= ST_DONE;
                ST_DONE:  state_reg <= ST_OUT;
                ST_OUT:
                    if (m_axis_tready) state_reg <= ST_IDLE;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                op_reg <= s_axis_tdata[4:0];
                dst_reg <= widx(s_axis_tdata[12:5]);
                lidx_reg <= widx(s_axis_tdata[20:13]);
                ridx_reg <= widx(s_axis_tdata[28:21]);
                imm_reg <= s_axis_tdata[92:29];
            end
            ST_READ:
            begin
                cnt_reg <= '0;
                carry_reg <= (op == OP_SUB);
                eq_reg <= 1'b1;
                lt_reg <= 1'b0;
                anz_reg <= 1'b0;
                acc_reg <= '0;
            end
            ST_RUN:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == '0)
                begin
                    // load operands, magnitudes for signed division
                    neg_reg <= sdiv && (rd_a_reg[DATA_W-1] ^ rd_b_reg[DATA_W-1]);
                    a_reg <= (op == OP_CONST) ? imm_reg : rd_a_reg;
                    b_reg <= is_mul ? rd_a_reg :
                             ((sdiv && rd_b_reg[DATA_W-1]) ? -rd_b_reg : rd_b_reg);
                    q_reg <= (sdiv && rd_a_reg[DATA_W-1]) ? -rd_a_reg :
                             (is_mul ? rd_b_reg : rd_a_reg);
                end
                else if (is_div)
                begin
                    if (!rem_sub[DATA_W])
                    begin
                        acc_reg <= rem_sub[DATA_W-1:0];
                        q_reg <= {q_reg[DATA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_reg <= rem_sh[DATA_W-1:0];
                        q_reg <= {q_reg[DATA_W-2:0], 1'b0};
                    end
                end
                else if (is_mul)
                begin
                    // shift-add, product low half shifts into a_reg
                    {acc_reg, a_reg} <= {madd, a_reg[DATA_W-1:1]};
                    q_reg <= q_reg >> 1;
                end
                else
                begin
                    carry_reg <= (abit & bbit) | (carry_reg & (abit ^ bbit));
                    eq_reg <= eq_reg && (a_reg[0] == b_reg[0]);
                    lt_reg <= d_lt;
                    anz_reg <= anz_reg | a_reg[0];
                    acc_reg <= {((op == OP_COPY) || (op == OP_CONST)) ? a_reg[0] : dbit,
                                acc_reg[DATA_W-1:1]};
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                end
            end
            ST_DONE:
            begin
                out_wd_reg <= res_wr;
                out_val_reg <= res_wr ? res_v : '0;
                out_tk_reg <= res_tk;
                out_err_reg <= res_err;
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata = {4'd0, out_err_reg, out_tk_reg, out_val_reg, out_wd_reg};

    ap_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_err_reg != ERR_NONE |-> !out_wd_reg)
        else $error("write reported with error");
    ap_zero_value_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !out_wd_reg |-> out_val_reg == '0)
        else $error("value without write");
    ap_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request taken while result pending");
    ap_taken_writes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_tk_reg |-> out_wd_reg)
        else $error("branch taken without write");

endmodule
`default_nettype wire
